[sv/b64dec_pkg.sv]
`timescale 1ns / 1ps

package b64dec_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 32;

	localparam logic [6:0] SEXTET_PAD = 7'd64;
	localparam logic [6:0] SEXTET_BAD = 7'd127;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_FINAL = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_RETAIN  = 2'd0,
		REG_MAX_ENC = 2'd1,
		REG_MAX_DEC = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_index_t;

	// Maps a UTF-16 code unit to its sextet; padding and illegal characters get
	// codes of their own above the six-bit range.
	function automatic logic [6:0] sextet_of(input logic [15:0] c);
		logic [6:0] r;
		if (c >= 16'h0041 && c <= 16'h005a) begin
			r = 7'(c - 16'h0041);
		end else if (c >= 16'h0061 && c <= 16'h007a) begin
			r = 7'(c - 16'h0061 + 16'd26);
		end else if (c >= 16'h0030 && c <= 16'h0039) begin
			r = 7'(c - 16'h0030 + 16'd52);
		end else if (c == 16'h002b) begin
			r = 7'd62;
		end else if (c == 16'h002f) begin
			r = 7'd63;
		end else if (c == 16'h003d) begin
			r = SEXTET_PAD;
		end else begin
			r = SEXTET_BAD;
		end
		return r;
	endfunction

endpackage

[sv/strict_base64_stream_decoder_core.sv]
`timescale 1ns / 1ps

// Strict base64 decoder taking one character request per cycle on s_axis and
// giving one result per cycle on m_axis while m_axis_tready is high. Each
// request is registered, decoded by a single layer of logic and placed in a
// result register, and a request whose result is a single status word leaves
// room for a new request in every cycle while the receiver is ready. While a
// result waits, the input register takes one more request and then holds
// s_axis_tready low. A request that completes a group with retain_data set gives
// one result per decoded byte, one to three in all, and holds the result register
// until the last is taken; that register sets the rate. Configuration writes are
// taken at any time but must only be made while no request is in flight.
module strict_base64_stream_decoder_core
	import b64dec_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // char_code[15:0]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// data_byte[7:0], ok[8], done_flag[9], encoded_count[41:10],
	// decoded_count[73:42], zero[79:74]
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tuser,  // byte_valid[0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	logic                   retain_q;
	logic [31:0]            max_enc_q;
	logic [31:0]            max_dec_q;

	logic                   valid_q;
	logic                   fin_q;
	logic [COUNT_WIDTH-1:0] enc_q;
	logic [COUNT_WIDTH-1:0] dec_q;
	logic [1:0]             fill_q;
	logic [6:0]             held_q [3];

	logic                   valid_s1;
	op_t                    op_s1;
	logic [15:0]            char_s1;

	logic                   valid_s2;
	logic [7:0]             byte_s2 [3];
	logic                   bv_s2;
	logic [1:0]             idx_s2;
	logic [1:0]             last_s2;
	logic                   ok_s2;
	logic                   done_s2;
	logic [31:0]            enc_s2;
	logic [31:0]            dec_s2;

	logic                   s2_free;
	logic                   adv;
	logic                   s_fire;
	logic                   m_fire;

	logic [6:0]             sx;
	logic [6:0]             a_sx;
	logic [6:0]             b_sx;
	logic [6:0]             c_sx;
	logic                   enc_at_lim;
	logic                   add_ok;
	logic                   struct_ok;
	logic                   padded;
	logic [1:0]             nb;
	logic [CMP_W:0]         dec_sum;
	logic                   lim_ok;
	logic [7:0]             gbyte [3];

	logic                   valid_d;
	logic                   fin_d;
	logic [COUNT_WIDTH-1:0] enc_d;
	logic [COUNT_WIDTH-1:0] dec_d;
	logic [1:0]             fill_d;
	logic                   held_we;
	logic                   emit_bytes;

	assign cfg_ready = 1'b1;

	assign m_fire  = m_axis_tvalid && m_axis_tready;
	assign s_fire  = s_axis_tvalid && s_axis_tready;
	assign s2_free = !valid_s2 || (m_axis_tready && (idx_s2 == last_s2));
	assign adv     = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	assign sx   = sextet_of(char_s1);
	assign a_sx = held_q[0];
	assign b_sx = held_q[1];
	assign c_sx = held_q[2];

	assign enc_at_lim = (CMP_W'(enc_q) >= CMP_W'(max_enc_q)) || (&enc_q);
	assign add_ok     = valid_q && !fin_q && !enc_at_lim && (sx != SEXTET_BAD);

	always_comb begin
		struct_ok = (a_sx != SEXTET_PAD) && (b_sx != SEXTET_PAD);
		if (c_sx == SEXTET_PAD) begin
			struct_ok = struct_ok && (sx == SEXTET_PAD) && (b_sx[3:0] == 4'd0);
			nb        = 2'd1;
			padded    = 1'b1;
		end else if (sx == SEXTET_PAD) begin
			struct_ok = struct_ok && (c_sx[1:0] == 2'd0);
			nb        = 2'd2;
			padded    = 1'b1;
		end else begin
			nb        = 2'd3;
			padded    = 1'b0;
		end
	end

	assign dec_sum = (CMP_W + 1)'(dec_q) + (CMP_W + 1)'(nb);
	assign lim_ok  = (dec_sum <= (CMP_W + 1)'(max_dec_q)) &&
		(dec_sum <= (CMP_W + 1)'({COUNT_WIDTH{1'b1}}));

	assign gbyte[0] = {a_sx[5:0], b_sx[5:4]};
	assign gbyte[1] = {b_sx[3:0], c_sx[5:2]};
	assign gbyte[2] = {c_sx[1:0], sx[5:0]};

	always_comb begin
		valid_d    = valid_q;
		fin_d      = fin_q;
		enc_d      = enc_q;
		dec_d      = dec_q;
		fill_d     = fill_q;
		held_we    = 1'b0;
		emit_bytes = 1'b0;
		case (op_s1)
			OP_ADD: begin
				if (!add_ok) begin
					valid_d = 1'b0;
				end else begin
					enc_d = enc_q + COUNT_WIDTH'(1);
					if (fill_q != 2'd3) begin
						held_we = 1'b1;
						fill_d  = fill_q + 2'd1;
					end else begin
						fill_d = 2'd0;
						if (struct_ok && padded) begin
							fin_d = 1'b1;
						end
						if (struct_ok && lim_ok) begin
							dec_d      = dec_sum[COUNT_WIDTH-1:0];
							emit_bytes = retain_q;
						end else begin
							valid_d = 1'b0;
						end
					end
				end
			end
			OP_FINAL: begin
				valid_d = valid_q && (fill_q == 2'd0);
			end
			OP_CLEAR: begin
				valid_d = 1'b1;
				fin_d   = 1'b0;
				enc_d   = '0;
				dec_d   = '0;
				fill_d  = 2'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_q  <= 1'b1;
			max_enc_q <= '1;
			max_dec_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_RETAIN:  retain_q  <= cfg_data[0];
				REG_MAX_ENC: max_enc_q <= cfg_data;
				REG_MAX_DEC: max_dec_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b1;
			fin_q   <= 1'b0;
			enc_q   <= '0;
			dec_q   <= '0;
			fill_q  <= 2'd0;
		end else if (adv) begin
			valid_q <= valid_d;
			fin_q   <= fin_d;
			enc_q   <= enc_d;
			dec_q   <= dec_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && held_we) begin
			held_q[fill_q] <= sx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1   <= op_t'(s_axis_tuser);
			char_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
			last_s2  <= 2'd0;
			bv_s2    <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
			last_s2  <= emit_bytes ? (nb - 2'd1) : 2'd0;
			bv_s2    <= emit_bytes;
		end else if (m_fire) begin
			if (idx_s2 == last_s2) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s2[0] <= emit_bytes ? gbyte[0] : 8'd0;
			byte_s2[1] <= emit_bytes ? gbyte[1] : 8'd0;
			byte_s2[2] <= emit_bytes ? gbyte[2] : 8'd0;
			ok_s2      <= valid_d;
			done_s2    <= fin_d;
			enc_s2     <= 32'(CMP_W'(enc_d));
			dec_s2     <= 32'(CMP_W'(dec_d));
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = bv_s2;
	assign m_axis_tlast  = (idx_s2 == last_s2);
	assign m_axis_tdata  = {6'd0, dec_s2, enc_s2, done_s2, ok_s2, byte_s2[idx_s2]};

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 <= last_s2))
		else $error("result index passed the last byte of the group");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !bv_s2) |-> (last_s2 == 2'd0))
		else $error("status result spread over more than one beat");

	a_finished_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (fill_q == 2'd0))
		else $error("finished stream holds a partial group");

	a_bytes_need_retain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bv_s2) |-> retain_q)
		else $error("decoded byte emitted with retain_data clear");

	a_count_moves_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv) |-> $stable(enc_q))
		else $error("encoded count changed without a request");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
	import b64dec_pkg::*;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        last;
		logic        ok;
		logic        done;
		logic [31:0] enc_count;
		logic [31:0] dec_count;
	} b64_result_t;

	typedef struct {
		op_t         op;
		logic [15:0] ch;
		bit          typed;
		b64_result_t want;
	} b64_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = OP_NONE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_RETAIN;
	logic [31:0] cfg_data = '0;

	strict_base64_stream_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic        keep_bytes = 1'b1;
	logic [31:0] enc_limit = '1;
	logic [31:0] dec_limit = '1;
	logic        st_valid = 1'b1;
	logic        st_finished = 1'b0;
	logic [31:0] st_enc = '0;
	logic [31:0] st_dec = '0;
	logic [1:0]  st_fill = '0;
	logic [6:0]  st_held [3];

	b64_result_t  pending_results [$];
	b64_request_t stim_q [$];
	b64_request_t opening [24];
	int unsigned  mismatches = 0;
	bit           gaps_on = 1'b1;
	int unsigned  stall_asked = 0;
	int unsigned  stall_served = 0;

	function automatic void queue_result(input b64_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic void add_stim(input b64_request_t r);
		stim_q = {stim_q, r};
	endfunction

	function automatic logic [6:0] sextet_code(input logic [15:0] ch);
		if (ch >= 16'h41 && ch <= 16'h5a) return 7'(ch - 16'h41);
		if (ch >= 16'h61 && ch <= 16'h7a) return 7'(ch - 16'h61 + 16'd26);
		if (ch >= 16'h30 && ch <= 16'h39) return 7'(ch - 16'h30 + 16'd52);
		if (ch == 16'h2b) return 7'd62;
		if (ch == 16'h2f) return 7'd63;
		if (ch == 16'h3d) return SEXTET_PAD;
		return SEXTET_BAD;
	endfunction

	function automatic logic [15:0] alphabet_char(input int unsigned s);
		if (s < 26) return 16'h41 + 16'(s);
		if (s < 52) return 16'h61 + 16'(s - 26);
		if (s < 62) return 16'h30 + 16'(s - 52);
		if (s == 62) return 16'h2b;
		return 16'h2f;
	endfunction

	function automatic b64_request_t plain(input op_t op, input logic [15:0] ch);
		b64_request_t r;
		r.op = op;
		r.ch = ch;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic b64_request_t settled(input op_t op, input logic [15:0] ch, input bit ok,
			input bit done, input logic [31:0] enc, input logic [31:0] dec);
		b64_request_t r;
		r = plain(op, ch);
		r.typed = 1'b1;
		r.want.last = 1'b1;
		r.want.ok = ok;
		r.want.done = done;
		r.want.enc_count = enc;
		r.want.dec_count = dec;
		return r;
	endfunction

	function automatic string show(input b64_result_t r);
		return $sformatf("byte=%02h bv=%b last=%b ok=%b done=%b enc=%0d dec=%0d",
			r.data_byte, r.byte_valid, r.last, r.ok, r.done, r.enc_count, r.dec_count);
	endfunction

	task automatic decode_request(input op_t op, input logic [15:0] ch);
		logic [6:0]      s;
		logic [7:0]      out_bytes [3];
		int unsigned     nb;
		int unsigned     emit;
		int unsigned     i;
		bit              bad;
		longint unsigned room;
		b64_result_t     r;
		emit = 0;
		out_bytes[0] = '0;
		out_bytes[1] = '0;
		out_bytes[2] = '0;
		case (op)
			OP_ADD: begin
				s = sextet_code(ch);
				if (!st_valid || st_finished || st_enc >= enc_limit || st_enc == '1 ||
						s == SEXTET_BAD) begin
					st_valid = 1'b0;
				end else begin
					st_enc++;
					if (st_fill < 3) begin
						st_held[st_fill] = s;
						st_fill++;
					end else begin
						bad = (st_held[0] == SEXTET_PAD) || (st_held[1] == SEXTET_PAD);
						nb = 3;
						out_bytes[0] = {st_held[0][5:0], st_held[1][5:4]};
						if (!bad) begin
							if (st_held[2] == SEXTET_PAD) begin
								if (s != SEXTET_PAD || st_held[1][3:0] != 4'd0) begin
									bad = 1'b1;
								end else begin
									st_finished = 1'b1;
									nb = 1;
								end
							end else begin
								out_bytes[1] = {st_held[1][3:0], st_held[2][5:2]};
								out_bytes[2] = {st_held[2][1:0], s[5:0]};
								if (s == SEXTET_PAD) begin
									if (st_held[2][1:0] != 2'd0) begin
										bad = 1'b1;
									end else begin
										st_finished = 1'b1;
										nb = 2;
									end
								end
							end
						end
						if (!bad) begin
							if (st_dec > dec_limit) begin
								bad = 1'b1;
							end else begin
								room = dec_limit - st_dec;
								if (nb > room || nb > 32'hffff_ffff - st_dec) begin
									bad = 1'b1;
								end else begin
									st_dec += nb;
								end
							end
						end
						st_fill = '0;
						if (bad) begin
							st_valid = 1'b0;
						end else if (keep_bytes) begin
							emit = nb;
						end
					end
				end
			end
			OP_FINAL: st_valid = st_valid && st_fill == 2'd0;
			OP_CLEAR: begin
				st_valid = 1'b1;
				st_finished = 1'b0;
				st_enc = '0;
				st_dec = '0;
				st_fill = '0;
			end
			default: ;
		endcase
		r.ok = st_valid;
		r.done = st_finished;
		r.enc_count = st_enc;
		r.dec_count = st_dec;
		if (emit == 0) begin
			r.data_byte = '0;
			r.byte_valid = 1'b0;
			r.last = 1'b1;
			queue_result(r);
		end else begin
			for (i = 0; i < emit; i++) begin
				r.data_byte = out_bytes[i];
				r.byte_valid = 1'b1;
				r.last = (i == emit - 1);
				queue_result(r);
			end
		end
	endtask

	task automatic send_request(input b64_request_t it);
		while (gaps_on && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= it.ch;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		decode_request(it.op, it.ch);
		if (it.typed) pending_results[$] = it.want;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_RETAIN:  keep_bytes = val[0];
			REG_MAX_ENC: enc_limit = val;
			REG_MAX_DEC: dec_limit = val;
			default: ;
		endcase
	endtask

	task automatic plan_transfer();
		int unsigned kind;
		int unsigned tail;
		int unsigned pick;
		logic [5:0]  a;
		logic [5:0]  b;
		logic [5:0]  c;
		logic [15:0] ch;
		kind = $urandom_range(99);
		if (kind < 72) begin
			add_stim(plain(OP_CLEAR, 16'($urandom)));
			repeat ($urandom_range(4) * 4)
				add_stim(plain(OP_ADD, alphabet_char($urandom_range(63))));
			tail = $urandom_range(2);
			a = 6'($urandom);
			b = 6'($urandom);
			c = 6'($urandom);
			if (tail == 1) begin
				if ($urandom_range(99) >= 15) b[3:0] = '0;
				add_stim(plain(OP_ADD, alphabet_char(a)));
				add_stim(plain(OP_ADD, alphabet_char(b)));
				add_stim(plain(OP_ADD, 16'h3d));
				add_stim(plain(OP_ADD, 16'h3d));
			end else if (tail == 2) begin
				if ($urandom_range(99) >= 15) c[1:0] = '0;
				add_stim(plain(OP_ADD, alphabet_char(a)));
				add_stim(plain(OP_ADD, alphabet_char(b)));
				add_stim(plain(OP_ADD, alphabet_char(c)));
				add_stim(plain(OP_ADD, 16'h3d));
			end
			if ($urandom_range(99) < 70) add_stim(plain(OP_FINAL, 16'($urandom)));
		end else if (kind < 88) begin
			repeat ($urandom_range(1, 8)) begin
				pick = $urandom_range(2);
				if (pick == 0) ch = 16'($urandom);
				else if (pick == 1) ch = 16'($urandom_range(16'h7e, 16'h20));
				else ch = alphabet_char($urandom_range(63));
				add_stim(plain(op_t'(2'($urandom_range(3))), ch));
			end
		end else begin
			add_stim(plain(OP_CLEAR, 16'($urandom)));
			repeat ($urandom_range(1, 7)) begin
				if ($urandom_range(99) < 25) ch = 16'h3d;
				else ch = alphabet_char($urandom_range(63));
				add_stim(plain(OP_ADD, ch));
			end
			add_stim(plain(OP_FINAL, 16'($urandom)));
		end
	endtask

	task automatic run_phase(input bit retain, input logic [31:0] enc_max,
			input logic [31:0] dec_max, input int unsigned target, input bit mid_pause,
			input bit stall, input bit gaps);
		int unsigned i;
		wait_idle();
		gaps_on = gaps;
		write_reg(REG_RETAIN, {31'd0, retain});
		write_reg(REG_MAX_ENC, enc_max);
		write_reg(REG_MAX_DEC, dec_max);
		cfg_valid <= 1'b0;
		while (stim_q.size() < target) plan_transfer();
		if (stall) stall_asked++;
		for (i = 0; i < stim_q.size(); i++) begin
			send_request(stim_q[i]);
			if (mid_pause && i == stim_q.size() / 2) wait_idle();
		end
		stim_q.delete();
	endtask

	// The receiver follows the random pattern, takes every result when gaps are off,
	// or, when asked, refuses every result for a long stretch so that requests back up into the block.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_asked != stall_served) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_served++;
			end else if (gaps_on) begin
				m_axis_tready <= ($urandom_range(99) >= 32);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		b64_result_t got;
		b64_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[8],
				m_axis_tdata[9], m_axis_tdata[41:10], m_axis_tdata[73:42]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches < 20)
					$display("%0t: unexpected result, expected none, actual %s", $time, show(got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches < 20)
						$display("%0t: result mismatch, expected %s, actual %s", $time,
							show(want), show(got));
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		opening = '{
			settled(OP_NONE, 16'h0000, 1, 0, 0, 0),
			settled(OP_FINAL, 16'h0000, 1, 0, 0, 0),
			plain(OP_ADD, 16'h54), plain(OP_ADD, 16'h57),
			plain(OP_ADD, 16'h46), plain(OP_ADD, 16'h75),
			plain(OP_ADD, 16'h2b), plain(OP_ADD, 16'h2f),
			plain(OP_ADD, 16'h30), plain(OP_ADD, 16'h39),
			settled(OP_FINAL, 16'hffff, 1, 0, 8, 6),
			plain(OP_ADD, 16'h61), plain(OP_ADD, 16'h7a),
			plain(OP_ADD, 16'h41), plain(OP_ADD, 16'h3d),
			settled(OP_ADD, 16'h41, 0, 1, 12, 8),
			settled(OP_CLEAR, 16'h0000, 1, 0, 0, 0),
			settled(OP_ADD, 16'hffff, 0, 0, 0, 0),
			settled(OP_CLEAR, 16'hffff, 1, 0, 0, 0),
			plain(OP_ADD, 16'h51),
			settled(OP_FINAL, 16'h0000, 0, 0, 1, 0),
			settled(OP_CLEAR, 16'h0000, 1, 0, 0, 0),
			settled(OP_ADD, 16'h0000, 0, 0, 0, 0),
			settled(OP_CLEAR, 16'h0000, 1, 0, 0, 0)
		};
		#1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i]) send_request(opening[i]);
		run_phase(1'b1, '1, '1, 60, 1'b1, 1'b0, 1'b1);
		run_phase(1'b0, '1, '1, 50, 1'b0, 1'b0, 1'b1);
		run_phase(1'b1, '0, '0, 30, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, $urandom_range(30, 3), $urandom_range(20), 70, 1'b0, 1'b1, 1'b1);
		run_phase(1'b0, $urandom_range(30, 3), $urandom_range(20), 50, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, '1, 32'd7, 50, 1'b0, 1'b0, 1'b1);
		run_phase(1'b1, '1, '1, 50, 1'b0, 1'b0, 1'b1);
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
sv/b64dec_pkg.sv
sv/strict_base64_stream_decoder_core.sv
sim/tb.sv
